### rtl/uplink_packet_deframer_assert.svh
// assertion macros shared by the deframer rtl
`ifndef UPLINK_PACKET_DEFRAMER_ASSERT_SVH
`define UPLINK_PACKET_DEFRAMER_ASSERT_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is active
`define UPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// clocked check, also held during reset
`define UPD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UPD_ASSERT(lbl, prop, msg)
`define UPD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/upd_pkg.sv
// shared types and constants for the uplink packet deframer
`timescale 1ns / 1ps
`default_nettype none
package upd_pkg;

	localparam int unsigned NumCmds = 3;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [3:0] StartNibble = 4'b0110;
	localparam logic [2:0] CmdAddr = 3'd1;

	localparam logic [CfgIdxW-1:0] RegCmd0Len = 2'd0;
	localparam logic [CfgIdxW-1:0] RegCmd1Len = 2'd1;
	localparam logic [CfgIdxW-1:0] RegCmd2Len = 2'd2;

	localparam logic [7:0] Cmd0LenRst = 8'd8;
	localparam logic [7:0] Cmd1LenRst = 8'd1;
	localparam logic [7:0] Cmd2LenRst = 8'd2;

	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StBadStart = 2'd1;
	localparam logic [1:0] StUnknown = 2'd2;

	typedef struct packed {
		logic [7:0] cmd0;
		logic [7:0] cmd1;
		logic [7:0] cmd2;
	} cmd_len_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] address;
		logic       is_data;
		logic [7:0] length_or_command;
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic       last;
	} res_t;

endpackage
`default_nettype wire

### rtl/upd_cfg_regs.sv
// command length registers written over the configuration port
`timescale 1ns / 1ps
`default_nettype none
module upd_cfg_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic [upd_pkg::CfgIdxW-1:0] wr_index,
	input  wire logic [7:0]                  wr_data,
	output upd_pkg::cmd_len_t                cmd_len
);
	import upd_pkg::*;

	cmd_len_t len_q;

	// register write, indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q.cmd0 <= Cmd0LenRst;
			len_q.cmd1 <= Cmd1LenRst;
			len_q.cmd2 <= Cmd2LenRst;
		end else if (wr_en) begin
			unique case (wr_index)
				RegCmd0Len: len_q.cmd0 <= wr_data;
				RegCmd1Len: len_q.cmd1 <= wr_data;
				RegCmd2Len: len_q.cmd2 <= wr_data;
				default: ;
			endcase
		end
	end

	assign cmd_len = len_q;

endmodule
`default_nettype wire

### rtl/upd_parser.sv
// packet state machine: header, second byte and payload count
`timescale 1ns / 1ps
`default_nettype none
module upd_parser (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte,
	input  upd_pkg::cmd_len_t cmd_len,
	output logic            has_res,
	output upd_pkg::res_t   res
);
	import upd_pkg::*;

	localparam logic [1:0] PhHeader = 2'd0;
	localparam logic [1:0] PhSecond = 2'd1;
	localparam logic [1:0] PhPayload = 2'd2;

	logic [1:0] phase_q, phase_d;
	logic [7:0] header_q, header_d;
	logic [7:0] second_q, second_d;
	logic [7:0] left_q, left_d;
	logic [7:0] len;
	logic [7:0] left_dec;

	// command length lookup, only used for known codes
	always_comb begin
		case (rx_byte[1:0])
			2'd0: len = cmd_len.cmd0;
			2'd1: len = cmd_len.cmd1;
			default: len = cmd_len.cmd2;
		endcase
	end

	assign left_dec = left_q - 8'd1;

	// next state and result for one item
	always_comb begin
		phase_d = phase_q;
		header_d = header_q;
		second_d = second_q;
		left_d = left_q;
		has_res = 1'b0;
		res.status = StOk;
		res.address = header_q[3:1];
		res.is_data = header_q[0];
		res.length_or_command = second_q;
		res.payload_valid = 1'b0;
		res.payload_byte = 8'd0;
		res.last = 1'b1;
		unique case (phase_q)
			PhSecond: begin
				second_d = rx_byte;
				res.length_or_command = rx_byte;
				if (header_q[7:4] != StartNibble) begin
					phase_d = PhHeader;
					has_res = 1'b1;
					res.status = StBadStart;
				end else if (header_q[0]) begin
					if (rx_byte == 8'd0) begin
						phase_d = PhHeader;
						has_res = 1'b1;
					end else begin
						phase_d = PhPayload;
						left_d = rx_byte;
					end
				end else if (header_q[3:1] > CmdAddr || rx_byte >= 8'(NumCmds)) begin
					phase_d = PhHeader;
					has_res = 1'b1;
					res.status = StUnknown;
				end else if (header_q[3:1] != CmdAddr || len == 8'd0) begin
					phase_d = PhHeader;
					has_res = 1'b1;
				end else begin
					phase_d = PhPayload;
					left_d = len;
				end
			end
			PhPayload: begin
				left_d = left_dec;
				has_res = 1'b1;
				res.payload_valid = 1'b1;
				res.payload_byte = rx_byte;
				res.last = (left_dec == 8'd0);
				if (left_dec == 8'd0) begin
					phase_d = PhHeader;
				end
			end
			default: begin
				// header byte, unused code behaves the same
				header_d = rx_byte;
				second_d = 8'd0;
				left_d = 8'd0;
				phase_d = PhSecond;
			end
		endcase
	end

	// state registers advance once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhHeader;
			header_q <= 8'd0;
			second_q <= 8'd0;
			left_q <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			header_q <= header_d;
			second_q <= second_d;
			left_q <= left_d;
		end
	end

endmodule
`default_nettype wire

### rtl/uplink_packet_deframer.sv
// top level of the uplink packet deframer
// an accepted item is held in the input register, then moves on to the result register once that register can advance
// throughput: one item per cycle, limited only by the output stall
// while a finished result waits to be taken the input register holds one more item
// reset (arst_n low, asynchronous) empties both registers, returns the parser
// to the header phase and loads the command lengths 8, 1 and 2
`timescale 1ns / 1ps
`default_nettype none
`include "uplink_packet_deframer_assert.svh"
module uplink_packet_deframer (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [7:0]                  rx_byte,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [upd_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [7:0]                  cfg_data,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [1:0]                       status,
	output logic [2:0]                       address,
	output logic                             is_data,
	output logic [7:0]                       length_or_command,
	output logic                             payload_valid,
	output logic [7:0]                       payload_byte,
	output logic                             last
);
	import upd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	res_t       res_q;
	logic       adv;
	logic       in_take;
	logic       step;
	logic       has_res;
	res_t       res;
	cmd_len_t   cmd_len;

	// handshake control
	assign adv = !out_valid_q || !out_stall;
	assign step = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;
	assign in_take = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	upd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cmd_len  (cmd_len)
	);

	upd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.cmd_len (cmd_len),
		.has_res (has_res),
		.res     (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take || (valid_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= rx_byte;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= step && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status = res_q.status;
	assign address = res_q.address;
	assign is_data = res_q.is_data;
	assign length_or_command = res_q.length_or_command;
	assign payload_valid = res_q.payload_valid;
	assign payload_byte = res_q.payload_byte;
	assign last = res_q.last;

	// checks
	`UPD_ASSERT(a_pb_zero, out_valid_q && !res_q.payload_valid |-> res_q.payload_byte == 8'd0, "payload byte set without payload valid")
	`UPD_ASSERT(a_err_last, out_valid_q && res_q.status != StOk |-> res_q.last && !res_q.payload_valid, "error result not a final header-only item")
	`UPD_ASSERT(a_stall_why, in_stall |-> valid_s1 && out_valid_q && out_stall, "input stalled without a held result")
	`UPD_ASSERT_ALWAYS(a_rst_empty, !arst_n |-> !out_valid_q && !valid_s1, "registers not empty in reset")

endmodule
`default_nettype wire
